FILE: rtl/cabm_pkg.sv
`default_nettype none
package cabm_pkg;

    localparam int COORD_W      = 32;
    localparam int FRAC_W       = 16;
    localparam int WEIGHT_W     = 17;
    localparam int WEIGHT_SHIFT = 30;

    // working widths of the arc datapath
    localparam int S_W    = COORD_W + 2;
    localparam int MAG_W  = COORD_W + 1;
    localparam int RAD_W  = COORD_W - 1;
    localparam int SS_W   = 2 * COORD_W + 4;
    localparam int RR_W   = 2 * COORD_W - 2;
    localparam int NUM_W  = 3 * COORD_W + 2;
    localparam int DEN_W  = SS_W + 1;
    localparam int Q_W    = COORD_W + 1;
    localparam int X_W    = SS_W + WEIGHT_SHIFT;
    localparam int ROOT_W = X_W / 2;
    localparam int V_W    = COORD_W + 3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
    localparam logic [RAD_W-1:0]    RADIUS_ONE = RAD_W'(1) << FRAC_W;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED   = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      last_point;
    } cabm_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] ctrl_x;
        logic signed [COORD_W-1:0] ctrl_y;
        logic signed [COORD_W-1:0] ctrl_z;
        logic [WEIGHT_W-1:0]       arc_weight;
        logic                      degenerate;
        logic                      last_segment;
    } cabm_out_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } cabm_point_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cabm_unit_st_t;

    typedef enum logic [2:0] {
        ARC_IDLE, ARC_SQ, ARC_SQRT, ARC_WDIV, ARC_RSQ, ARC_RMUL, ARC_ODIV, ARC_DONE
    } cabm_arc_state_t;

    typedef enum logic [1:0] {
        TOP_IDLE, TOP_RUN, TOP_PUT
    } cabm_top_state_t;

endpackage
`default_nettype wire

FILE: rtl/cabm_mul.sv
`default_nettype none
module cabm_mul #(
    parameter int A_W = 16,
    parameter int B_W = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [A_W-1:0]       a,
    input  wire logic [B_W-1:0]       b,
    output logic [A_W+B_W-1:0]        prod,
    output cabm_pkg::cabm_unit_st_t   status
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [P_W-1:0]   acc_reg;
    logic [P_W-1:0]   mc_reg;
    logic [B_W-1:0]   mp_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg && start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(B_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // one multiplier bit per cycle, lsb first
    always_ff @(posedge aclk) begin
        if (!busy_reg && start) begin
            acc_reg <= '0;
            mc_reg  <= {{B_W{1'b0}}, a};
            mp_reg  <= b;
        end else if (busy_reg) begin
            if (mp_reg[0]) begin
                acc_reg <= acc_reg + mc_reg;
            end
            mc_reg <= {mc_reg[P_W-2:0], 1'b0};
            mp_reg <= {1'b0, mp_reg[B_W-1:1]};
        end
    end

    assign prod        = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire

FILE: rtl/cabm_div.sv
`default_nettype none
module cabm_div #(
    parameter int N_W = 32,
    parameter int D_W = 16,
    parameter int Q_W = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [N_W-1:0]       num,
    input  wire logic [D_W-1:0]       den,
    output logic [Q_W-1:0]            quot,
    output logic                      ovf,
    output cabm_pkg::cabm_unit_st_t   status
);

    localparam int H_W   = N_W - Q_W;
    localparam int CMP_W = (H_W > D_W) ? H_W : D_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [D_W-1:0]   rem_reg;
    logic [Q_W-1:0]   quo_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [CMP_W-1:0] hi_ext;
    logic [CMP_W-1:0] den_ext;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;
    logic             ge;

    assign hi_ext  = CMP_W'(num[N_W-1:Q_W]);
    assign den_ext = CMP_W'(den);
    assign trial   = {rem_reg, quo_reg[Q_W-1]};
    assign diff    = trial - {1'b0, den};
    assign ge      = trial >= {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg && start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(Q_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // high part above the quotient window decides overflow up front
    always_ff @(posedge aclk) begin
        if (!busy_reg && start) begin
            rem_reg <= hi_ext[D_W-1:0];
            quo_reg <= num[Q_W-1:0];
            ovf_reg <= hi_ext >= den_ext;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
            quo_reg <= {quo_reg[Q_W-2:0], ge};
        end
    end

    assign quot        = quo_reg;
    assign ovf         = ovf_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire

FILE: rtl/cabm_sqrt.sv
`default_nettype none
module cabm_sqrt #(
    parameter int X_W = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [X_W-1:0]       x,
    output logic [X_W/2-1:0]          root,
    output cabm_pkg::cabm_unit_st_t   status
);

    localparam int R_W   = X_W / 2;
    localparam int CNT_W = $clog2(R_W + 1);

    logic [R_W+1:0]   rem_reg;
    logic [R_W-1:0]   root_reg;
    logic [X_W-1:0]   xs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [R_W+1:0] t;
    logic [R_W+1:0] trial;
    logic [R_W+1:0] diff;
    logic           ge;

    assign t     = {rem_reg[R_W-1:0], xs_reg[X_W-1 -: 2]};
    assign trial = {root_reg, 2'b01};
    assign diff  = t - trial;
    assign ge    = t >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg && start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(R_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // two radicand bits per cycle, one root bit out
    always_ff @(posedge aclk) begin
        if (!busy_reg && start) begin
            rem_reg  <= '0;
            root_reg <= '0;
            xs_reg   <= x;
        end else if (busy_reg) begin
            rem_reg  <= ge ? diff : t;
            root_reg <= {root_reg[R_W-2:0], ge};
            xs_reg   <= {xs_reg[X_W-3:0], 2'b00};
        end
    end

    assign root        = root_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire

FILE: rtl/cabm_arc.sv
`default_nettype none
module cabm_arc (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire cabm_pkg::cabm_point_t     b0,
    input  wire cabm_pkg::cabm_point_t     b2,
    input  wire cabm_pkg::cabm_point_t     center,
    input  wire logic [cabm_pkg::RAD_W-1:0] radius,
    output cabm_pkg::cabm_out_t            res,
    output logic                           done
);

    localparam int W      = cabm_pkg::COORD_W;
    localparam int S_W    = cabm_pkg::S_W;
    localparam int MAG_W  = cabm_pkg::MAG_W;
    localparam int RAD_W  = cabm_pkg::RAD_W;
    localparam int SS_W   = cabm_pkg::SS_W;
    localparam int RR_W   = cabm_pkg::RR_W;
    localparam int P_W    = RR_W + MAG_W;
    localparam int NUM_W  = cabm_pkg::NUM_W;
    localparam int DEN_W  = cabm_pkg::DEN_W;
    localparam int Q_W    = cabm_pkg::Q_W;
    localparam int X_W    = cabm_pkg::X_W;
    localparam int ROOT_W = cabm_pkg::ROOT_W;
    localparam int V_W    = cabm_pkg::V_W;
    localparam int WW     = cabm_pkg::WEIGHT_W;

    cabm_pkg::cabm_arc_state_t state_reg, state_next;
    logic [1:0] idx_reg, idx_next;

    logic signed [S_W-1:0] s_reg   [3];
    logic [MAG_W-1:0]      mag_reg [3];
    logic [SS_W-1:0]       ss_reg;
    logic [RR_W-1:0]       rr_reg;
    logic [NUM_W-1:0]      num_reg;
    logic signed [W-1:0]   ctrl_reg [3];
    logic [WW-1:0]         weight_reg;
    logic                  deg_reg;

    logic signed [W-1:0]   b0a [3];
    logic signed [W-1:0]   b2a [3];
    logic signed [W-1:0]   ca  [3];
    logic signed [S_W-1:0] s_c   [3];
    logic [MAG_W-1:0]      mag_c [3];

    logic                   mul_start, div_start, sqrt_start;
    logic [RR_W-1:0]        mul_a;
    logic [MAG_W-1:0]       mul_b;
    logic [P_W-1:0]         mul_prod;
    cabm_pkg::cabm_unit_st_t mul_st, div_st, sqrt_st;
    logic [NUM_W-1:0]       div_num;
    logic [DEN_W-1:0]       div_den;
    logic [Q_W-1:0]         div_quot;
    logic                   div_ovf;
    logic [ROOT_W-1:0]      sqrt_root;

    logic [SS_W-1:0]       sq_sum;
    logic [Q_W-1:0]        q_use;
    logic signed [V_W-1:0] c_ext, q_ext, v;
    logic [V_W-W:0]        v_top;
    logic                  fits;
    logic signed [W-1:0]   ctrl_c;
    logic [WW-1:0]         w_c;

    always_comb begin
        b0a[0] = b0.x; b0a[1] = b0.y; b0a[2] = b0.z;
        b2a[0] = b2.x; b2a[1] = b2.y; b2a[2] = b2.z;
        ca[0]  = center.x; ca[1] = center.y; ca[2] = center.z;
        for (int i = 0; i < 3; i++) begin
            s_c[i] = $signed({{2{b0a[i][W-1]}}, b0a[i]}) + $signed({{2{b2a[i][W-1]}}, b2a[i]})
                   - $signed({ca[i][W-1], ca[i], 1'b0});
            mag_c[i] = s_c[i][S_W-1] ? MAG_W'(-s_c[i]) : MAG_W'(s_c[i]);
        end
    end

    assign sq_sum = ss_reg + mul_prod[SS_W-1:0];

    // control point coordinate: centre plus or minus the rounded offset, saturated
    always_comb begin
        q_use  = div_ovf ? {Q_W{1'b1}} : div_quot;
        c_ext  = $signed({{3{ca[idx_reg][W-1]}}, ca[idx_reg]});
        q_ext  = $signed({2'b00, q_use});
        v      = s_reg[idx_reg][S_W-1] ? c_ext - q_ext : c_ext + q_ext;
        v_top  = v[V_W-1:W-1];
        fits   = (&v_top) || !(|v_top);
        if (fits) begin
            ctrl_c = v[W-1:0];
        end else if (v[V_W-1]) begin
            ctrl_c = {1'b1, {(W-1){1'b0}}};
        end else begin
            ctrl_c = {1'b0, {(W-1){1'b1}}};
        end
        if (div_ovf || div_quot > {{(Q_W-WW){1'b0}}, cabm_pkg::WEIGHT_ONE}) begin
            w_c = cabm_pkg::WEIGHT_ONE;
        end else begin
            w_c = div_quot[WW-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            cabm_pkg::ARC_IDLE: begin
                if (start) begin
                    state_next = cabm_pkg::ARC_SQ;
                    idx_next   = 2'd0;
                end
            end
            cabm_pkg::ARC_SQ: begin
                if (mul_st.done) begin
                    if (idx_reg == 2'd2) begin
                        idx_next   = 2'd0;
                        state_next = (sq_sum == '0) ? cabm_pkg::ARC_DONE : cabm_pkg::ARC_SQRT;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            cabm_pkg::ARC_SQRT: begin
                if (sqrt_st.done) state_next = cabm_pkg::ARC_WDIV;
            end
            cabm_pkg::ARC_WDIV: begin
                if (div_st.done) state_next = cabm_pkg::ARC_RSQ;
            end
            cabm_pkg::ARC_RSQ: begin
                if (mul_st.done) begin
                    state_next = cabm_pkg::ARC_RMUL;
                    idx_next   = 2'd0;
                end
            end
            cabm_pkg::ARC_RMUL: begin
                if (mul_st.done) state_next = cabm_pkg::ARC_ODIV;
            end
            cabm_pkg::ARC_ODIV: begin
                if (div_st.done) begin
                    if (idx_reg == 2'd2) begin
                        state_next = cabm_pkg::ARC_DONE;
                    end else begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = cabm_pkg::ARC_RMUL;
                    end
                end
            end
            cabm_pkg::ARC_DONE: begin
                state_next = cabm_pkg::ARC_IDLE;
            end
            default: begin
                state_next = cabm_pkg::ARC_IDLE;
            end
        endcase
    end

    // unit launches and operand selection
    always_comb begin
        mul_start  = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        mul_a      = {{(RR_W-MAG_W){1'b0}}, mag_reg[idx_reg]};
        mul_b      = mag_reg[idx_reg];
        div_num    = num_reg;
        div_den    = {ss_reg, 1'b0};
        done       = 1'b0;
        case (state_reg)
            cabm_pkg::ARC_SQ: begin
                mul_start = !mul_st.busy && !mul_st.done;
            end
            cabm_pkg::ARC_SQRT: begin
                sqrt_start = !sqrt_st.busy && !sqrt_st.done;
            end
            cabm_pkg::ARC_WDIV: begin
                div_start = !div_st.busy && !div_st.done;
                div_num   = {{(NUM_W-ROOT_W){1'b0}}, sqrt_root};
                div_den   = {{(DEN_W-RAD_W){1'b0}}, radius};
            end
            cabm_pkg::ARC_RSQ: begin
                mul_start = !mul_st.busy && !mul_st.done;
                mul_a     = {{(RR_W-RAD_W){1'b0}}, radius};
                mul_b     = {{(MAG_W-RAD_W){1'b0}}, radius};
            end
            cabm_pkg::ARC_RMUL: begin
                mul_start = !mul_st.busy && !mul_st.done;
                mul_a     = rr_reg;
            end
            cabm_pkg::ARC_ODIV: begin
                div_start = !div_st.busy && !div_st.done;
            end
            cabm_pkg::ARC_DONE: begin
                done = 1'b1;
            end
            default: begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cabm_pkg::ARC_IDLE;
            idx_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == cabm_pkg::ARC_IDLE && start) begin
            for (int i = 0; i < 3; i++) begin
                s_reg[i]   <= s_c[i];
                mag_reg[i] <= mag_c[i];
            end
            ss_reg  <= '0;
            deg_reg <= 1'b0;
        end
        if (state_reg == cabm_pkg::ARC_SQ && mul_st.done) begin
            ss_reg <= sq_sum;
            // chord midpoint on the centre
            if (idx_reg == 2'd2 && sq_sum == '0) begin
                for (int i = 0; i < 3; i++) begin
                    ctrl_reg[i] <= ca[i];
                end
                weight_reg <= '0;
                deg_reg    <= 1'b1;
            end
        end
        if (state_reg == cabm_pkg::ARC_WDIV && div_st.done) begin
            weight_reg <= w_c;
        end
        if (state_reg == cabm_pkg::ARC_RSQ && mul_st.done) begin
            rr_reg <= mul_prod[RR_W-1:0];
        end
        // 4 r^2 |s_i| + s.s over 2 s.s gives the rounded offset
        if (state_reg == cabm_pkg::ARC_RMUL && mul_st.done) begin
            num_reg <= {1'b0, mul_prod, 2'b00} + {{(NUM_W-SS_W){1'b0}}, ss_reg};
        end
        if (state_reg == cabm_pkg::ARC_ODIV && div_st.done) begin
            ctrl_reg[idx_reg] <= ctrl_c;
            if (!fits) deg_reg <= 1'b1;
        end
    end

    cabm_mul #(.A_W(RR_W), .B_W(MAG_W)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .a(mul_a), .b(mul_b), .prod(mul_prod), .status(mul_st)
    );

    cabm_div #(.N_W(NUM_W), .D_W(DEN_W), .Q_W(Q_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(div_den), .quot(div_quot), .ovf(div_ovf), .status(div_st)
    );

    cabm_sqrt #(.X_W(X_W)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sqrt_start),
        .x({ss_reg, {cabm_pkg::WEIGHT_SHIFT{1'b0}}}), .root(sqrt_root), .status(sqrt_st)
    );

    assign res.ctrl_x       = ctrl_reg[0];
    assign res.ctrl_y       = ctrl_reg[1];
    assign res.ctrl_z       = ctrl_reg[2];
    assign res.arc_weight   = weight_reg;
    assign res.degenerate   = deg_reg;
    assign res.last_segment = 1'b0;

endmodule
`default_nettype wire

FILE: rtl/circle_arc_bezier_midpoint.sv
`default_nettype none
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    cabm_in_t  (point, last mark)
// m_        out        m_valid / m_ready    cabm_out_t (control point, weight, flags)
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a point that opens a curve and is not its closing point makes no arc; each arc runs on
// the shared bit-serial multiplier (seven products), divider (four quotients) and square
// root. an arc whose chord midpoint sits on the centre finishes after the squares.
// a closing point in closed mode runs two arcs in turn when it follows an earlier point.
// synchronous active-low reset clears the curve state and restores the register defaults.
// one point is worked at a time; a held result beat does not stop the next point.
module circle_arc_bezier_midpoint (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire cabm_pkg::cabm_in_t                s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output cabm_pkg::cabm_out_t                    m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [cabm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cabm_pkg::COORD_W-1:0]      cfg_data
);

    cabm_pkg::cabm_top_state_t state_reg, state_next;

    cabm_pkg::cabm_point_t center_reg;
    logic [cabm_pkg::RAD_W-1:0] radius_reg;
    logic closed_reg;

    cabm_pkg::cabm_point_t first_reg, prev_reg, pt_reg, a0_reg;
    logic have_prev_reg;
    logic run2_reg;
    logic lastseg1_reg;
    logic arc_sel_reg;
    logic start_reg;
    logic m_valid_reg;
    cabm_pkg::cabm_out_t out_reg;
    cabm_pkg::cabm_out_t out_next;

    cabm_pkg::cabm_point_t p_in;
    cabm_pkg::cabm_point_t arc_b0, arc_b2;
    cabm_pkg::cabm_out_t   arc_res;
    logic arc_done;
    logic in_acc, out_free, load_out, launch, run1, run2;

    assign p_in.x = s_data.point_x;
    assign p_in.y = s_data.point_y;
    assign p_in.z = s_data.point_z;
    assign run1   = have_prev_reg;
    assign run2   = s_data.last_point && closed_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cabm_pkg::TOP_IDLE: begin
                if (s_valid && (run1 || run2)) state_next = cabm_pkg::TOP_RUN;
            end
            cabm_pkg::TOP_RUN: begin
                if (arc_done) state_next = cabm_pkg::TOP_PUT;
            end
            cabm_pkg::TOP_PUT: begin
                if (out_free) begin
                    state_next = (run2_reg && !arc_sel_reg) ? cabm_pkg::TOP_RUN
                                                            : cabm_pkg::TOP_IDLE;
                end
            end
            default: begin
                state_next = cabm_pkg::TOP_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            cabm_pkg::TOP_IDLE: s_ready  = 1'b1;
            cabm_pkg::TOP_PUT:  load_out = out_free;
            default:            s_ready  = 1'b0;
        endcase
        in_acc = s_valid && s_ready;
        launch = (in_acc && (run1 || run2)) || (load_out && run2_reg && !arc_sel_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cabm_pkg::TOP_IDLE;
            have_prev_reg <= 1'b0;
            start_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            center_reg    <= '0;
            radius_reg    <= cabm_pkg::RADIUS_ONE;
            closed_reg    <= 1'b0;
            first_reg     <= '0;
            prev_reg      <= '0;
        end else begin
            state_reg <= state_next;
            start_reg <= launch;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    cabm_pkg::CFG_CENTER_X: center_reg.x <= cfg_data;
                    cabm_pkg::CFG_CENTER_Y: center_reg.y <= cfg_data;
                    cabm_pkg::CFG_CENTER_Z: center_reg.z <= cfg_data;
                    cabm_pkg::CFG_RADIUS:   radius_reg   <= cfg_data[cabm_pkg::RAD_W-1:0];
                    cabm_pkg::CFG_CLOSED:   closed_reg   <= cfg_data[0];
                    default:                closed_reg   <= closed_reg;
                endcase
            end
            if (in_acc) begin
                if (!have_prev_reg) first_reg <= p_in;
                prev_reg      <= p_in;
                have_prev_reg <= !s_data.last_point;
            end
        end
    end

    always_comb begin
        out_next              = arc_res;
        out_next.last_segment = arc_sel_reg ? 1'b1 : lastseg1_reg;
    end

    // arc payload; the closing arc runs from this point back to the first
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            pt_reg       <= p_in;
            a0_reg       <= prev_reg;
            run2_reg     <= run2;
            lastseg1_reg <= s_data.last_point && !closed_reg;
            arc_sel_reg  <= !run1;
        end else if (load_out && run2_reg && !arc_sel_reg) begin
            arc_sel_reg <= 1'b1;
        end
        if (load_out) begin
            out_reg <= out_next;
        end
    end

    assign arc_b0 = arc_sel_reg ? pt_reg : a0_reg;
    assign arc_b2 = arc_sel_reg ? first_reg : pt_reg;

    cabm_arc u_arc (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg),
        .b0(arc_b0), .b2(arc_b2), .center(center_reg), .radius(radius_reg),
        .res(arc_res), .done(arc_done)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire
